>>> sv/cpt_pkg.sv
package cpt_pkg;

    // Default sample width (Q1.15 at 16 bits)
    localparam int CPT_SAMPLE_WIDTH = 16;

    // Unsigned Q0.16 transform coefficients
    localparam logic [16:0] K_TWO_THIRDS = 17'd43691;   // 2/3
    localparam logic [16:0] K_INV_SQRT3  = 17'd37837;   // 1/sqrt(3)
    localparam logic [16:0] K_SQRT3_HALF = 17'd56756;   // sqrt(3)/2

    typedef enum logic {
        MODE_FWD = 1'b0,    // abc to dq0
        MODE_INV = 1'b1     // dq0 to abc
    } t_mode;

    // Control that leaves the datapath pipeline with each transaction
    typedef struct packed {
        logic valid;
        logic clipped;
    } t_pipe_ctl;

endpackage

>>> sv/cpt_core.sv
module cpt_core #(
    parameter int SAMPLE_WIDTH = cpt_pkg::CPT_SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic                           i_mode,
    input  logic signed [SAMPLE_WIDTH-1:0] i_first,
    input  logic signed [SAMPLE_WIDTH-1:0] i_second,
    input  logic signed [SAMPLE_WIDTH-1:0] i_third,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sine,
    input  logic signed [SAMPLE_WIDTH-1:0] i_cosine,
    output cpt_pkg::t_pipe_ctl             o_ctl,
    output logic signed [SAMPLE_WIDTH-1:0] o_first,
    output logic signed [SAMPLE_WIDTH-1:0] o_second,
    output logic signed [SAMPLE_WIDTH-1:0] o_third,
    output logic signed [SAMPLE_WIDTH-1:0] o_alpha,
    output logic signed [SAMPLE_WIDTH-1:0] o_beta
);
    import cpt_pkg::*;

    localparam int W  = SAMPLE_WIDTH;
    localparam int CW = W + 20;                     // coefficient products, phase sums
    localparam int RW = 2 * W + 1;                  // rotation sums
    localparam int SW = (RW > CW) ? RW : CW;        // saturation input

    localparam logic signed [17:0] KS_TWO_THIRDS = $signed({1'b0, K_TWO_THIRDS});
    localparam logic signed [17:0] KS_INV_SQRT3  = $signed({1'b0, K_INV_SQRT3});
    localparam logic signed [17:0] KS_SQRT3_HALF = $signed({1'b0, K_SQRT3_HALF});

    localparam logic signed [CW-1:0]   RND_17  = CW'(1 << 16);
    localparam logic signed [W+18:0]   RND_16B = (W + 19)'(1 << 15);
    localparam logic signed [CW-1:0]   RND_16  = CW'(1 << 15);
    localparam logic signed [RW-1:0]   RND_ROT = RW'(1) <<< (W - 2);

    // Clip to the sample range; the top bit of the result is the clip flag
    function automatic logic [W:0] sat(input logic signed [SW-1:0] x);
        logic [SW-W:0] hi_bits;
        logic          fits;
        hi_bits = x[SW-1:W-1];
        fits    = (&hi_bits) | ~(|hi_bits);
        if (fits) begin
            sat = {1'b0, x[W-1:0]};
        end else begin
            sat = {1'b1, x[SW-1], {(W-1){~x[SW-1]}}};
        end
    endfunction

    // Valid bits
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld;

    // Stage 1: Clarke pre-sums
    t_mode                  r1_mode;
    logic signed [W-1:0]    r1_x1, r1_x2, r1_x3, r1_sn, r1_cs;
    logic signed [W+1:0]    r1_sa, r1_sz;
    logic signed [W:0]      r1_sb;
    logic signed [W+1:0]    n1_sa, n1_sz;
    logic signed [W:0]      n1_sb;

    // Stage 2: Clarke coefficient products
    t_mode                  r2_mode;
    logic signed [W-1:0]    r2_x1, r2_x2, r2_x3, r2_sn, r2_cs;
    logic signed [CW-1:0]   r2_pa, r2_pz;
    logic signed [W+18:0]   r2_pb;

    // Stage 3: rounded, saturated stationary frame (forward) or the dq0 inputs (inverse)
    t_mode                  r3_mode;
    logic signed [W-1:0]    r3_u, r3_v, r3_z, r3_sn, r3_cs;
    logic                   r3_clip;
    logic signed [CW-1:0]   n3_ta, n3_tz;
    logic signed [W+18:0]   n3_tb;
    logic signed [W-1:0]    n3_alpha, n3_beta, n3_zero, n3_u, n3_v, n3_z;
    logic                   n3_ca, n3_cb, n3_cz, n3_clip;

    // Stage 4: rotation products
    t_mode                  r4_mode;
    logic signed [W-1:0]    r4_u, r4_v, r4_z;
    logic                   r4_clip;
    logic signed [2*W-1:0]  r4_p1, r4_p2, r4_p3, r4_p4;

    // Stage 5: rotation sums
    t_mode                  r5_mode;
    logic signed [W-1:0]    r5_u, r5_v, r5_z, r5_a, r5_b;
    logic                   r5_clip;
    logic signed [RW-1:0]   n5_t1, n5_t2;
    logic signed [W-1:0]    n5_a, n5_b;
    logic                   n5_c1, n5_c2;

    // Stage 6: sqrt(3)/2 product for the inverse phases
    t_mode                  r6_mode;
    logic signed [W-1:0]    r6_u, r6_v, r6_z, r6_a, r6_b;
    logic                   r6_clip;
    logic signed [W+17:0]   r6_kb;

    // Stage 7 (combinational into the output register)
    logic signed [CW-1:0]   n7_az, n7_ah, n7_hz, n7_kb, n7_t1, n7_t2, n7_t3;
    logic signed [W-1:0]    n7_r1, n7_r2, n7_r3;
    logic                   n7_c1, n7_c2, n7_c3;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    // Stage 1: form 2a-b-c, b-c and a+b+c
    always_comb begin
        n1_sa = ((W + 2)'(i_first) <<< 1) - (W + 2)'(i_second) - (W + 2)'(i_third);
        n1_sb = (W + 1)'(i_second) - (W + 1)'(i_third);
        n1_sz = (W + 2)'(i_first) + (W + 2)'(i_second) + (W + 2)'(i_third);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mode <= t_mode'(i_mode);
            r1_x1   <= i_first;
            r1_x2   <= i_second;
            r1_x3   <= i_third;
            r1_sn   <= i_sine;
            r1_cs   <= i_cosine;
            r1_sa   <= n1_sa;
            r1_sb   <= n1_sb;
            r1_sz   <= n1_sz;
        end
    end

    // Stage 2: scale by 2/3 and 1/sqrt(3)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_mode <= r1_mode;
            r2_x1   <= r1_x1;
            r2_x2   <= r1_x2;
            r2_x3   <= r1_x3;
            r2_sn   <= r1_sn;
            r2_cs   <= r1_cs;
            r2_pa   <= KS_TWO_THIRDS * r1_sa;
            r2_pb   <= KS_INV_SQRT3 * r1_sb;
            r2_pz   <= KS_INV_SQRT3 * r1_sz;
        end
    end

    // Stage 3: round and clip alpha, beta, zero; pick rotation operands
    always_comb begin
        n3_ta = r2_pa + RND_17;
        n3_tb = r2_pb + RND_16B;
        n3_tz = r2_pz + RND_16;
        {n3_ca, n3_alpha} = sat(SW'(n3_ta >>> 17));
        {n3_cb, n3_beta}  = sat(SW'(n3_tb >>> 16));
        {n3_cz, n3_zero}  = sat(SW'(n3_tz >>> 16));
        if (r2_mode == MODE_INV) begin
            n3_u    = r2_x1;
            n3_v    = r2_x2;
            n3_z    = r2_x3;
            n3_clip = 1'b0;
        end else begin
            n3_u    = n3_alpha;
            n3_v    = n3_beta;
            n3_z    = n3_zero;
            n3_clip = n3_ca | n3_cb | n3_cz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_mode <= r2_mode;
            r3_u    <= n3_u;
            r3_v    <= n3_v;
            r3_z    <= n3_z;
            r3_sn   <= r2_sn;
            r3_cs   <= r2_cs;
            r3_clip <= n3_clip;
        end
    end

    // Stage 4: four rotation products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_mode <= r3_mode;
            r4_u    <= r3_u;
            r4_v    <= r3_v;
            r4_z    <= r3_z;
            r4_clip <= r3_clip;
            r4_p1   <= r3_u * r3_cs;
            r4_p2   <= r3_v * r3_sn;
            r4_p3   <= r3_u * r3_sn;
            r4_p4   <= r3_v * r3_cs;
        end
    end

    // Stage 5: combine, round and clip the rotation
    always_comb begin
        if (r4_mode == MODE_INV) begin
            n5_t1 = RW'(r4_p1) - RW'(r4_p2) + RND_ROT;
            n5_t2 = RW'(r4_p3) + RW'(r4_p4) + RND_ROT;
        end else begin
            n5_t1 = RW'(r4_p1) + RW'(r4_p2) + RND_ROT;
            n5_t2 = RW'(r4_p4) - RW'(r4_p3) + RND_ROT;
        end
        {n5_c1, n5_a} = sat(SW'(n5_t1 >>> (W - 1)));
        {n5_c2, n5_b} = sat(SW'(n5_t2 >>> (W - 1)));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_mode <= r4_mode;
            r5_u    <= r4_u;
            r5_v    <= r4_v;
            r5_z    <= r4_z;
            r5_a    <= n5_a;
            r5_b    <= n5_b;
            r5_clip <= r4_clip | n5_c1 | n5_c2;
        end
    end

    // Stage 6: scale beta by sqrt(3)/2
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_mode <= r5_mode;
            r6_u    <= r5_u;
            r6_v    <= r5_v;
            r6_z    <= r5_z;
            r6_a    <= r5_a;
            r6_b    <= r5_b;
            r6_clip <= r5_clip;
            r6_kb   <= KS_SQRT3_HALF * r5_b;
        end
    end

    // Stage 7: inverse phases, then select the result
    always_comb begin
        n7_az = CW'(r6_a) <<< 16;
        n7_ah = CW'(r6_a) <<< 15;
        n7_hz = CW'(r6_z) <<< 15;
        n7_kb = CW'(r6_kb);
        n7_t1 = n7_az + n7_hz + RND_16;
        n7_t2 = n7_hz - n7_ah + n7_kb + RND_16;
        n7_t3 = n7_hz - n7_ah - n7_kb + RND_16;
        {n7_c1, n7_r1} = sat(SW'(n7_t1 >>> 16));
        {n7_c2, n7_r2} = sat(SW'(n7_t2 >>> 16));
        {n7_c3, n7_r3} = sat(SW'(n7_t3 >>> 16));

        o_ctl.valid = r6_vld;
        if (r6_mode == MODE_INV) begin
            o_first       = n7_r1;
            o_second      = n7_r2;
            o_third       = n7_r3;
            o_alpha       = r6_a;
            o_beta        = r6_b;
            o_ctl.clipped = r6_clip | n7_c1 | n7_c2 | n7_c3;
        end else begin
            o_first       = r6_a;
            o_second      = r6_b;
            o_third       = r6_z;
            o_alpha       = r6_u;
            o_beta        = r6_v;
            o_ctl.clipped = r6_clip;
        end
    end

endmodule

>>> sv/clarke_park_transform.sv
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+--------------------------------------------
// input   | in        | i_valid / o_stall  | i_mode, i_in_first..third, i_sine, i_cosine
// output  | out       | o_valid / i_stall  | o_out_first..third, o_alpha_out, o_beta_out,
//         |           |                    | o_clipped
//
// One transaction per cycle while o_stall is low; each passes through the multiply and
// round/clip stages of the datapath pipeline and then the output register.
// Reset (synchronous, active low) empties the pipeline, output and skid registers.
// A stalled output parks one result in a skid register; o_stall is that
// register's full flag, so the pipeline freezes for as long as it is occupied.
module clarke_park_transform #(
    parameter int SAMPLE_WIDTH = cpt_pkg::CPT_SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_mode,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_first,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_second,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_third,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sine,
    input  logic signed [SAMPLE_WIDTH-1:0] i_cosine,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_first,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_second,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_third,
    output logic signed [SAMPLE_WIDTH-1:0] o_alpha_out,
    output logic signed [SAMPLE_WIDTH-1:0] o_beta_out,
    output logic                           o_clipped
);
    import cpt_pkg::*;

    localparam int W  = SAMPLE_WIDTH;
    localparam int DW = 5 * W + 1;

    t_pipe_ctl           core_ctl;
    logic signed [W-1:0] core_first, core_second, core_third, core_alpha, core_beta;
    logic                pipe_en;
    logic                pipe_vld;
    logic                out_free;
    logic [DW-1:0]       pipe_data;

    logic                r_out_vld;
    logic [DW-1:0]       r_out_data;
    logic                r_skid_vld;
    logic [DW-1:0]       r_skid_data;

    cpt_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .i_first  (i_in_first),
        .i_second (i_in_second),
        .i_third  (i_in_third),
        .i_sine   (i_sine),
        .i_cosine (i_cosine),
        .o_ctl    (core_ctl),
        .o_first  (core_first),
        .o_second (core_second),
        .o_third  (core_third),
        .o_alpha  (core_alpha),
        .o_beta   (core_beta)
    );

    // Freeze the pipeline while a result sits in the skid register
    assign pipe_en   = ~r_skid_vld;
    assign pipe_vld  = core_ctl.valid & pipe_en;
    assign out_free  = ~r_out_vld | ~i_stall;
    assign pipe_data = {core_ctl.clipped, core_beta, core_alpha,
                        core_third, core_second, core_first};

    // Output and skid valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= pipe_vld;
            end
        end else if (pipe_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    // Output and skid payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data <= r_skid_vld ? r_skid_data : pipe_data;
        end
        if (!out_free && pipe_vld) begin
            r_skid_data <= pipe_data;
        end
    end

    assign o_stall      = r_skid_vld;
    assign o_valid      = r_out_vld;
    assign o_out_first  = r_out_data[W-1:0];
    assign o_out_second = r_out_data[2*W-1:W];
    assign o_out_third  = r_out_data[3*W-1:2*W];
    assign o_alpha_out  = r_out_data[4*W-1:3*W];
    assign o_beta_out   = r_out_data[5*W-1:4*W];
    assign o_clipped    = r_out_data[DW-1];

endmodule

>>> sv/cpt_checker.sv
module cpt_checker #(
    parameter int SAMPLE_WIDTH = cpt_pkg::CPT_SAMPLE_WIDTH
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_stall,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic signed [SAMPLE_WIDTH-1:0] o_out_first,
    input logic signed [SAMPLE_WIDTH-1:0] o_out_second,
    input logic signed [SAMPLE_WIDTH-1:0] o_out_third,
    input logic signed [SAMPLE_WIDTH-1:0] o_alpha_out,
    input logic signed [SAMPLE_WIDTH-1:0] o_beta_out,
    input logic                           o_clipped
);
    import cpt_pkg::*;

    // Reset empties the output side and releases the input
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output valid or input stall after reset");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_first) && $stable(o_out_second)
            && $stable(o_out_third) && $stable(o_alpha_out) && $stable(o_beta_out)
            && $stable(o_clipped))
        else $error("stalled result changed");

    // A full skid register implies a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

    // Drain the skid register as soon as the output moves
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall && !i_stall |=> !o_stall)
        else $error("input stall held after output transaction");

    // Stall on the input only after the output stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall raised without output stall");

endmodule

bind clarke_park_transform cpt_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_cpt_checker (.*);

>>> sim/clarke_park_transform_tb.sv
`timescale 1ns / 100ps

module clarke_park_transform_tb;
    import cpt_pkg::*;

    localparam int W = CPT_SAMPLE_WIDTH;
    localparam int FB = W - 1;

    typedef logic signed [W-1:0] t_sample;

    typedef struct packed {
        t_mode   mode;
        t_sample first;
        t_sample second;
        t_sample third;
        t_sample sine;
        t_sample cosine;
    } t_sample_set;

    typedef struct packed {
        t_sample first;
        t_sample second;
        t_sample third;
        t_sample alpha;
        t_sample beta;
        logic    clipped;
    } t_frame;

    typedef struct packed {
        t_sample_set stim;
        bit          typed;
        t_frame      want;
    } t_vector;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_valid = 1'b0;
    logic    i_stall = 1'b0;
    logic    i_mode = 1'b0;
    t_sample i_in_first = '0;
    t_sample i_in_second = '0;
    t_sample i_in_third = '0;
    t_sample i_sine = '0;
    t_sample i_cosine = '0;
    logic    o_stall;
    logic    o_valid;
    t_sample o_out_first;
    t_sample o_out_second;
    t_sample o_out_third;
    t_sample o_alpha_out;
    t_sample o_beta_out;
    logic    o_clipped;

    t_frame frames_due[$];
    int     errors = 0;
    int     n_fwd = 0;
    int     n_inv = 0;
    int     n_results = 0;
    int     n_clipped = 0;
    int     n_in_stalled = 0;
    int     tx_gap_pct = 0;
    int     rx_stall_pct = 0;
    bit     hold_request = 1'b0;

    clarke_park_transform dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_in_first  (i_in_first),
        .i_in_second (i_in_second),
        .i_in_third  (i_in_third),
        .i_sine      (i_sine),
        .i_cosine    (i_cosine),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_first (o_out_first),
        .o_out_second(o_out_second),
        .o_out_third (o_out_third),
        .o_alpha_out (o_alpha_out),
        .o_beta_out  (o_beta_out),
        .o_clipped   (o_clipped)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Clamp to the sample range
    function automatic longint clamp_sample(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << FB) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Round (p1 + p2) / 2^FB half up, halving first to keep headroom
    function automatic longint round_pair(longint p1, longint p2);
        longint h;
        longint carry;
        h = (p1 >>> 1) + (p2 >>> 1);
        carry = longint'(p1[0]) + longint'(p2[0]);
        return (h + (longint'(1) << (FB - 2)) + (carry >>> 1)) >>> (FB - 1);
    endfunction

    // Predict one frame: Clarke then Park forward, or inverse Park then inverse Clarke
    function automatic t_frame dq0_transform(t_sample_set s);
        longint x1, x2, x3, sn, cs;
        longint k23, kis3, ks3h, half_z;
        longint al, be, r1, r2, r3, v;
        logic   clip;
        t_frame res;
        x1 = s.first;
        x2 = s.second;
        x3 = s.third;
        sn = s.sine;
        cs = s.cosine;
        k23 = K_TWO_THIRDS;
        kis3 = K_INV_SQRT3;
        ks3h = K_SQRT3_HALF;
        clip = 1'b0;
        if (s.mode == MODE_FWD) begin
            v = (k23 * (2 * x1 - x2 - x3) + (longint'(1) << 16)) >>> 17;
            al = clamp_sample(v); clip |= (al != v);
            v = (kis3 * (x2 - x3) + (longint'(1) << 15)) >>> 16;
            be = clamp_sample(v); clip |= (be != v);
            v = (kis3 * (x1 + x2 + x3) + (longint'(1) << 15)) >>> 16;
            r3 = clamp_sample(v); clip |= (r3 != v);
            v = round_pair(al * cs, be * sn);
            r1 = clamp_sample(v); clip |= (r1 != v);
            v = round_pair(-(al * sn), be * cs);
            r2 = clamp_sample(v); clip |= (r2 != v);
        end else begin
            half_z = x3 * 32768;
            v = round_pair(x1 * cs, -(x2 * sn));
            al = clamp_sample(v); clip |= (al != v);
            v = round_pair(x1 * sn, x2 * cs);
            be = clamp_sample(v); clip |= (be != v);
            v = (al * 65536 + half_z + 32768) >>> 16;
            r1 = clamp_sample(v); clip |= (r1 != v);
            v = (-al * 32768 + ks3h * be + half_z + 32768) >>> 16;
            r2 = clamp_sample(v); clip |= (r2 != v);
            v = (-al * 32768 - ks3h * be + half_z + 32768) >>> 16;
            r3 = clamp_sample(v); clip |= (r3 != v);
        end
        res.first = r1[W-1:0];
        res.second = r2[W-1:0];
        res.third = r3[W-1:0];
        res.alpha = al[W-1:0];
        res.beta = be[W-1:0];
        res.clipped = clip;
        return res;
    endfunction

    function automatic t_sample_set set_of(t_mode m, int a, int b, int c, int sn, int cs);
        t_sample_set s;
        s.mode = m;
        s.first = a[W-1:0];
        s.second = b[W-1:0];
        s.third = c[W-1:0];
        s.sine = sn[W-1:0];
        s.cosine = cs[W-1:0];
        return s;
    endfunction

    // Table row checked against the predictor
    function automatic t_vector plain(t_mode m, int a, int b, int c, int sn, int cs);
        t_vector r;
        r.stim = set_of(m, a, b, c, sn, cs);
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    // Table row with the result written out by hand
    function automatic t_vector checked(t_mode m, int a, int b, int c, int sn, int cs,
                                        int e1, int e2, int e3, int ea, int eb, bit ec);
        t_vector r;
        r.stim = set_of(m, a, b, c, sn, cs);
        r.typed = 1'b1;
        r.want.first = e1[W-1:0];
        r.want.second = e2[W-1:0];
        r.want.third = e3[W-1:0];
        r.want.alpha = ea[W-1:0];
        r.want.beta = eb[W-1:0];
        r.want.clipped = ec;
        return r;
    endfunction

    function automatic t_sample edge_or_any();
        case ($urandom_range(0, 5))
            0: return t_sample'(32767);
            1: return t_sample'(-32768);
            2: return t_sample'(0);
            3: return t_sample'(1);
            4: return t_sample'(-1);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // Balanced three-phase or dq sets on the unit circle, else raw or corner values
    function automatic t_sample_set make_set();
        t_sample_set s;
        real th;
        real ph;
        real amp;
        int pick;
        pick = $urandom_range(0, 9);
        s.mode = t_mode'($urandom_range(0, 1));
        if (pick < 4) begin
            th = 6.283185307 * $urandom_range(0, 65535) / 65536.0;
            ph = 6.283185307 * $urandom_range(0, 65535) / 65536.0;
            amp = $urandom_range(0, 32767);
            s.sine = t_sample'($rtoi(32767.0 * $sin(th)));
            s.cosine = t_sample'($rtoi(32767.0 * $cos(th)));
            if (s.mode == MODE_FWD) begin
                s.first = t_sample'($rtoi(amp * $cos(ph)));
                s.second = t_sample'($rtoi(amp * $cos(ph - 2.0943951)));
                s.third = t_sample'($rtoi(amp * $cos(ph + 2.0943951)));
            end else begin
                s.first = t_sample'($rtoi(amp * $cos(ph)));
                s.second = t_sample'($rtoi(amp * $sin(ph)));
                s.third = t_sample'($urandom_range(0, 2047) - 1024);
            end
        end else if (pick < 7) begin
            s.first = t_sample'($urandom);
            s.second = t_sample'($urandom);
            s.third = t_sample'($urandom);
            s.sine = t_sample'($urandom);
            s.cosine = t_sample'($urandom);
        end else begin
            s.first = edge_or_any();
            s.second = edge_or_any();
            s.third = edge_or_any();
            s.sine = edge_or_any();
            s.cosine = edge_or_any();
        end
        return s;
    endfunction

    function automatic int idle_length();
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Drive one transaction, hold it until accepted, then optionally drop valid
    task automatic offer(t_sample_set s, t_frame want, int gap);
        i_valid <= 1'b1;
        i_mode <= s.mode;
        i_in_first <= s.first;
        i_in_second <= s.second;
        i_in_third <= s.third;
        i_sine <= s.sine;
        i_cosine <= s.cosine;
        @(posedge i_clk);
        while (o_stall) begin
            n_in_stalled++;
            @(posedge i_clk);
        end
        frames_due.push_back(want);
        if (s.mode == MODE_FWD) n_fwd++;
        else n_inv++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic run_random(int n, int tx_pct, int rx_pct);
        t_sample_set s;
        int gap;
        tx_gap_pct = tx_pct;
        rx_stall_pct = rx_pct;
        for (int k = 0; k < n; k++) begin
            s = make_set();
            gap = ($urandom_range(0, 99) < tx_gap_pct) ? idle_length() : 0;
            offer(s, dq0_transform(s), gap);
        end
        i_valid <= 1'b0;
    endtask

    task automatic wait_results_done();
        while (frames_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(string name, t_sample want, t_sample got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare one output transaction with the oldest prediction
    task automatic compare_result();
        t_frame want;
        n_results++;
        if (o_clipped === 1'b1) n_clipped++;
        if (frames_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                     $time, o_out_first, o_out_second, o_out_third);
            errors++;
            return;
        end
        want = frames_due.pop_front();
        check_field("out_first", want.first, o_out_first);
        check_field("out_second", want.second, o_out_second);
        check_field("out_third", want.third, o_out_third);
        check_field("alpha_out", want.alpha, o_alpha_out);
        check_field("beta_out", want.beta, o_beta_out);
        check_field("clipped", t_sample'(want.clipped), t_sample'(o_clipped));
    endtask

    // Receiver: check results, drive random stall runs and the long hold-off
    initial begin
        int run_left;
        int hold_left;
        run_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && !i_stall) compare_result();
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = 200;
                run_left = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (run_left > 0) begin
                run_left--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
                run_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                                        : $urandom_range(0, 3);
            end
        end
    end

    // Sender and run control
    initial begin
        t_vector rows[$];
        rows.push_back(checked(MODE_FWD, 0, 0, 0, 0, 32767, 0, 0, 0, 0, 0, 1'b0));
        // zero sequence overflows both ways
        rows.push_back(checked(MODE_FWD, 32767, 32767, 32767, 12345, -2222,
                               0, 0, 32767, 0, 0, 1'b1));
        rows.push_back(checked(MODE_FWD, -32768, -32768, -32768, -32768, 32767,
                               0, 0, -32768, 0, 0, 1'b1));
        rows.push_back(checked(MODE_INV, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        rows.push_back(checked(MODE_INV, 0, 0, 32767, 32767, 32767,
                               16384, 16384, 16384, 0, 0, 1'b0));
        rows.push_back(checked(MODE_INV, 0, 0, -32768, -32768, -32768,
                               -16384, -16384, -16384, 0, 0, 1'b0));
        rows.push_back(plain(MODE_FWD, 32767, -32768, -32768, 0, 32767));
        rows.push_back(plain(MODE_FWD, -32768, 32767, 32767, 32767, 0));
        // trig out of range
        rows.push_back(plain(MODE_FWD, 0, 32767, -32768, -32768, -32768));
        rows.push_back(plain(MODE_FWD, 12000, -6000, -6000, 23170, 23170));
        rows.push_back(plain(MODE_FWD, 32767, 0, 0, 0, 32767));
        rows.push_back(plain(MODE_FWD, 1, -1, 0, 1, -1));
        rows.push_back(plain(MODE_FWD, -32768, 32767, -32768, 32767, 32767));
        rows.push_back(plain(MODE_INV, 32767, 32767, 0, 32767, 32767));
        rows.push_back(plain(MODE_INV, -32768, -32768, -32768, -32768, -32768));
        rows.push_back(plain(MODE_INV, 32767, -32768, 32767, 32767, -32768));
        rows.push_back(plain(MODE_INV, 10000, 5000, 0, 0, 32767));
        rows.push_back(plain(MODE_INV, -1, 1, -1, -1, 1));
        rows.push_back(plain(MODE_INV, 32767, 0, 0, 0, 32767));
        rows.push_back(plain(MODE_INV, 0, 32767, -32768, 23170, -23170));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, back to back
        rx_stall_pct = 25;
        foreach (rows[r]) offer(rows[r].stim,
                                rows[r].typed ? rows[r].want : dq0_transform(rows[r].stim), 0);
        i_valid <= 1'b0;
        wait_results_done();

        run_random(500, 30, 30);

        // Long output hold-off while input keeps coming, then pause to drain
        hold_request = 1'b1;
        run_random(300, 0, 20);
        wait_results_done();

        run_random(400, 0, 0);
        run_random(430, 60, 50);

        rx_stall_pct = 10;
        wait_results_done();
        repeat (20) @(posedge i_clk);

        $display("tb: %0d forward and %0d inverse transactions, %0d results (%0d clipped)",
                 n_fwd, n_inv, n_results, n_clipped);
        $display("tb: input held off for %0d cycles by back-pressure", n_in_stalled);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
